>>> rtl/max_collinear_points_macros.svh
// Assertion macros shared by the checker.
`ifndef MAX_COLLINEAR_POINTS_MACROS_SVH
`define MAX_COLLINEAR_POINTS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/mcp_pkg.sv
`default_nettype none
package mcp_pkg;
  localparam int MAX_POINTS = 512;
  localparam int COORD_BITS = 16;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int IW = $clog2(MAX_POINTS) + 1;
  localparam int CB = COORD_BITS;

  typedef struct packed {
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] x;
  } point_t;

  typedef struct packed {
    logic start;
    logic valid;
    logic dup;
  } cnt_ctrl_t;

  function automatic logic signed [CB-1:0] sext_coord(input logic [15:0] v);
    return $signed(v[CB-1:0]);
  endfunction
endpackage
`default_nettype wire

>>> rtl/mcp_cell.sv
`default_nettype none
module mcp_cell import mcp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   en,
  input  wire point_t d,
  output point_t      q
);
  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/mcp_chain.sv
`default_nettype none
module mcp_chain import mcp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   en,
  input  wire logic   load,
  input  wire point_t load_point,
  output point_t      tail
);
  point_t link [MAX_POINTS+1];

  // The head takes a new point while loading and the tail point while rotating.
  assign link[0] = load ? load_point : link[MAX_POINTS];
  assign tail    = link[MAX_POINTS];

  for (genvar c = 0; c < MAX_POINTS; c++) begin : g_cell
    mcp_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (link[c]),
      .q   (link[c+1])
    );
  end
endmodule
`default_nettype wire

>>> rtl/mcp_count.sv
`default_nettype none
module mcp_count import mcp_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cnt_ctrl_t       ctrl,
  input  wire point_t          anchor,
  input  wire logic signed [CB:0] dx,
  input  wire logic signed [CB:0] dy,
  input  wire point_t          pt,
  output logic [IW-1:0]        count
);
  logic                       v1, v2;
  logic                       eq1, eq2;
  logic signed [CB:0]         ex, ey;
  logic signed [2*CB+1:0]     p1, p2;

  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      count <= '0;
    end else begin
      v1 <= ctrl.valid;
      v2 <= v1;
      if (v2 && (ctrl.dup ? eq2 : (p1 == p2))) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ex  <= {pt.x[CB-1], pt.x} - {anchor.x[CB-1], anchor.x};
    ey  <= {pt.y[CB-1], pt.y} - {anchor.y[CB-1], anchor.y};
    eq1 <= (pt.x == anchor.x) && (pt.y == anchor.y);
    p1  <= dx * ey;
    p2  <= dy * ex;
    eq2 <= eq1;
  end
endmodule
`default_nettype wire

>>> rtl/max_collinear_points.sv
`default_nettype none
// Collects up to MAX_POINTS points, one per input transfer, in a ring of
// cells, and on the transfer marked by tlast reports the largest number of
// points on one straight line, using exact integer cross products. Loading
// takes one cycle per point. For a set of n points the sweep visits every
// pair (a, b) with a <= b, n(n+1)/2 pairs, each costing one ring rotation
// to fetch the pair and, unless a != b and the two points are equal, one
// rotation to count. Points past capacity are dropped and flagged in the
// result.
module max_collinear_points import mcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // point_x[15:0], point_y[31:16]
  input  wire logic        s_tlast,   // is_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // max_count[9:0], overflow[10], zero[15:11]
);
  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_CAP   = 6'b000010,
    S_PREP  = 6'b000100,
    S_CNT   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t             state;
  logic [IW-1:0]      n, ia, ib, best;
  logic [PW-1:0]      pos;
  logic [1:0]         dcnt;
  logic               dropped;
  point_t             anchor, partner, tail, in_point;
  logic signed [CB:0] dx, dy;
  logic [IW-1:0]      count;
  cnt_ctrl_t          ctrl;
  logic               accept, ring_en, ring_load, pos_end;
  logic [IW-1:0]      tail_idx;
  logic [IW-1:0]      ib_inc, ia_inc, nia, nib;
  logic               done;

  assign s_tready  = (state == S_LOAD);
  assign accept    = s_tvalid && s_tready;
  assign in_point  = '{y: sext_coord(s_tdata[31:16]), x: sext_coord(s_tdata[15:0])};
  assign ring_load = accept && (n < IW'(MAX_POINTS));
  assign ring_en   = ring_load || (state == S_CAP) || (state == S_CNT);
  assign pos_end   = (pos == PW'(MAX_POINTS - 1));
  // Cell c of the ring reaches the tail at rotation step MAX_POINTS-1-c.
  assign tail_idx  = {1'b0, PW'(MAX_POINTS - 1) - pos};

  assign ib_inc = ib + 1'b1;
  assign ia_inc = ia + 1'b1;
  assign nia    = (ib_inc == n) ? ia_inc : ia;
  assign nib    = (ib_inc == n) ? ia_inc : ib_inc;
  assign done   = (ib_inc == n) && (ia_inc == n);

  assign ctrl.start = (state == S_PREP);
  assign ctrl.valid = (state == S_CNT) && (tail_idx < n);
  assign ctrl.dup   = (ia == ib);

  mcp_chain u_chain (
    .clk        (clk),
    .en         (ring_en),
    .load       (ring_load),
    .load_point (in_point),
    .tail       (tail)
  );

  mcp_count u_count (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .anchor (anchor),
    .dx     (dx),
    .dy     (dy),
    .pt     (tail),
    .count  (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      n        <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
      pos      <= '0;
      dcnt     <= '0;
      ia       <= '0;
      ib       <= '0;
      best     <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (ring_load) begin
              n <= n + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (s_tlast) begin
              state <= S_CAP;
              ia    <= '0;
              ib    <= '0;
              pos   <= '0;
              best  <= IW'(1);
            end
          end
        end
        S_CAP: begin
          pos <= pos_end ? '0 : pos + 1'b1;
          if (pos_end) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // A pair of two distinct entries with equal points defines no line and is skipped.
          if ((ia != ib) && (anchor == partner)) begin
            ia    <= nia;
            ib    <= nib;
            state <= done ? S_OUT : S_CAP;
          end else begin
            state <= S_CNT;
          end
        end
        S_CNT: begin
          pos <= pos_end ? '0 : pos + 1'b1;
          if (pos_end) begin
            state <= S_DRAIN;
            dcnt  <= '0;
          end
        end
        S_DRAIN: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == 2'd2) begin
            if (count > best) begin
              best <= count;
            end
            ia    <= nia;
            ib    <= nib;
            state <= done ? S_OUT : S_CAP;
          end
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            n        <= '0;
            dropped  <= 1'b0;
            state    <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CAP) begin
      if (tail_idx == ia) begin
        anchor <= tail;
      end
      if (tail_idx == ib) begin
        partner <= tail;
      end
    end
    if (state == S_PREP) begin
      dx <= {partner.x[CB-1], partner.x} - {anchor.x[CB-1], anchor.x};
      dy <= {partner.y[CB-1], partner.y} - {anchor.y[CB-1], anchor.y};
    end
    if ((state == S_OUT) && !m_tvalid) begin
      m_tdata <= {5'd0, dropped, 10'(best)};
    end
  end
endmodule
`default_nettype wire

>>> rtl/mcp_checker.sv
`default_nettype none
`include "max_collinear_points_macros.svh"
module mcp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);
  // A stalled result stays offered and unchanged.
  `MCP_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
  `MCP_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
  // Every reported set has at least one point.
  `MCP_ASSERT_NOW(a_count_nonzero, m_tvalid, m_tdata[9:0] != 10'd0)
  `MCP_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:11] == 5'd0)
  // Closing a set starts the sweep, so no point is taken in the next cycle.
  `MCP_ASSERT_NEXT(a_sweep_blocks, s_tvalid && s_tready && s_tlast, !s_tready)
endmodule

bind max_collinear_points mcp_checker u_mcp_checker (.*);
`default_nettype wire
